// File: rtl/core/ufd_pkg.sv
// shared types and constants for the uart frame deframer
`default_nettype none

package ufd_pkg;

  localparam int ByteW = 8;
  localparam int WordW = 16;
  localparam int PosW  = 3;
  localparam int CfgIdxW = 2;

  // input item codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // command codes
  localparam logic [ByteW-1:0] CMD_DEVIATION = 8'h01;
  localparam logic [ByteW-1:0] CMD_DIGIT     = 8'h02;
  localparam logic [ByteW-1:0] CMD_STATUS    = 8'h03;
  localparam logic [ByteW-1:0] CMD_TRACK     = 8'h04;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADER  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FOOTER  = 2'd2;

  // configuration reset values
  localparam logic [ByteW-1:0] TIMEOUT_RST = 8'd10;
  localparam logic [ByteW-1:0] HEADER_RST  = 8'hAA;
  localparam logic [ByteW-1:0] FOOTER_RST  = 8'h55;

  // frame byte positions
  localparam logic [PosW-1:0] POS_FIRST = 3'd1;
  localparam logic [PosW-1:0] POS_LAST  = 3'd5;

  typedef struct packed {
    logic [ByteW-1:0] timeout_ticks;
    logic [ByteW-1:0] header_value;
    logic [ByteW-1:0] footer_value;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] data_hi;
    logic [ByteW-1:0] data_lo;
  } frame_t;

endpackage

`default_nettype wire

// File: rtl/core/ufd_front.sv
// front end: frame hunting, byte collection, timeout and frame checking
`default_nettype none

module ufd_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ufd_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_opcode,
  input  wire logic [ufd_pkg::ByteW-1:0]  in_rx_byte,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output ufd_pkg::frame_t                 push_frame
);

  logic                          collecting_r, collecting_nxt;
  logic [ufd_pkg::PosW-1:0]      pos_r, pos_nxt;
  logic [ufd_pkg::ByteW-1:0]     tick_r, tick_nxt;
  logic [ufd_pkg::ByteW-1:0]     frame_r [4];
  logic                          wr_en;
  logic [1:0]                    wr_idx;
  logic [ufd_pkg::ByteW-1:0]     tick_inc;
  logic [ufd_pkg::ByteW-1:0]     sum;
  logic                          accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = !push_ready;
  assign tick_inc = tick_r + 8'd1;
  assign sum      = frame_r[0] + frame_r[1] + frame_r[2];
  assign wr_idx   = 2'(pos_r - ufd_pkg::POS_FIRST);

  assign push_frame.cmd     = frame_r[0];
  assign push_frame.data_hi = frame_r[1];
  assign push_frame.data_lo = frame_r[2];

  always_comb begin
    collecting_nxt = collecting_r;
    pos_nxt        = pos_r;
    tick_nxt       = tick_r;
    wr_en          = 1'b0;
    push_valid     = 1'b0;
    if (accept) begin
      if (in_opcode == ufd_pkg::OP_TICK) begin
        if (collecting_r) begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg.timeout_ticks) begin
            collecting_nxt = 1'b0;
            pos_nxt        = '0;
          end
        end
      end else if (!collecting_r) begin
        if (in_rx_byte == cfg.header_value) begin
          collecting_nxt = 1'b1;
          pos_nxt        = ufd_pkg::POS_FIRST;
          tick_nxt       = '0;
        end
      end else if (pos_r >= ufd_pkg::POS_LAST) begin
        collecting_nxt = 1'b0;
        pos_nxt        = '0;
        push_valid     = (in_rx_byte == cfg.footer_value) && (sum == frame_r[3]);
      end else begin
        wr_en   = 1'b1;
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      pos_r        <= '0;
      tick_r       <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      pos_r        <= pos_nxt;
      tick_r       <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_r[wr_idx] <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ufd_fifo.sv
// short frame queue between front end and back end
`default_nettype none

module ufd_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire ufd_pkg::frame_t push_frame,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output ufd_pkg::frame_t      pop_frame
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  ufd_pkg::frame_t   mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != FullCnt);
  assign pop_valid  = (cnt_r != '0);
  assign pop_frame  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ufd_back.sv
// back end: command execution, held values and result register
`default_nettype none

module ufd_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             pop_valid,
  output logic                                  pop_ready,
  input  wire ufd_pkg::frame_t                  pop_frame,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic        [ufd_pkg::ByteW-1:0]      out_frame_cmd,
  output logic signed [ufd_pkg::WordW-1:0]      out_deviation,
  output logic        [ufd_pkg::ByteW-1:0]      out_digit,
  output logic        [ufd_pkg::ByteW-1:0]      out_link_status,
  output logic signed [ufd_pkg::WordW-1:0]      out_track,
  output logic                                  out_digit_upd,
  output logic                                  out_track_upd
);

  logic [ufd_pkg::WordW-1:0] dev_r, dev_nxt;
  logic [ufd_pkg::ByteW-1:0] digit_r, digit_nxt;
  logic [ufd_pkg::ByteW-1:0] status_r, status_nxt;
  logic [ufd_pkg::WordW-1:0] track_r, track_nxt;
  logic                      nd_nxt, nt_nxt;
  logic                      valid_r;
  logic [ufd_pkg::WordW-1:0] word;
  logic                      do_pop;

  logic        [ufd_pkg::ByteW-1:0] cmd_r;
  logic signed [ufd_pkg::WordW-1:0] dev_out_r;
  logic        [ufd_pkg::ByteW-1:0] digit_out_r;
  logic        [ufd_pkg::ByteW-1:0] status_out_r;
  logic signed [ufd_pkg::WordW-1:0] track_out_r;
  logic                             nd_r, nt_r;

  assign word      = {pop_frame.data_hi, pop_frame.data_lo};
  assign pop_ready = !valid_r || !out_stall;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    dev_nxt    = dev_r;
    digit_nxt  = digit_r;
    status_nxt = status_r;
    track_nxt  = track_r;
    nd_nxt     = 1'b0;
    nt_nxt     = 1'b0;
    unique case (pop_frame.cmd)
      ufd_pkg::CMD_DEVIATION: dev_nxt = word;
      ufd_pkg::CMD_DIGIT: begin
        digit_nxt = pop_frame.data_lo;
        nd_nxt    = 1'b1;
      end
      ufd_pkg::CMD_STATUS: status_nxt = pop_frame.data_lo;
      ufd_pkg::CMD_TRACK: begin
        track_nxt = word;
        nt_nxt    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      dev_r    <= '0;
      digit_r  <= '0;
      status_r <= '0;
      track_r  <= '0;
    end else begin
      if (do_pop) begin
        valid_r  <= 1'b1;
        dev_r    <= dev_nxt;
        digit_r  <= digit_nxt;
        status_r <= status_nxt;
        track_r  <= track_nxt;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      cmd_r        <= pop_frame.cmd;
      dev_out_r    <= $signed(dev_nxt);
      digit_out_r  <= digit_nxt;
      status_out_r <= status_nxt;
      track_out_r  <= $signed(track_nxt);
      nd_r         <= nd_nxt;
      nt_r         <= nt_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_frame_cmd   = cmd_r;
  assign out_deviation   = dev_out_r;
  assign out_digit       = digit_out_r;
  assign out_link_status = status_out_r;
  assign out_track       = track_out_r;
  assign out_digit_upd   = nd_r;
  assign out_track_upd   = nt_r;

endmodule

`default_nettype wire

// File: rtl/core/uart_frame_deframer_with_timeout.sv
// top level of the uart frame deframer with receive timeout
//
// input channel: in_valid / in_stall with in_opcode (0 byte, 1 millisecond tick)
// and in_rx_byte; a transfer happens when in_valid is high and in_stall is low.
// result channel: out_valid / out_stall with the accepted frame's command and
// the held deviation, digit, status and track plus digit_upd / track_upd flags.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_wdata; index 0
// timeout ticks, 1 header byte, 2 footer byte; write only while idle.
// throughput: one item per cycle while in_stall is low; the front end parses,
// a small queue of QUEUE_DEPTH frames decouples it from the back end and its
// result register. a checked frame is written into the queue at the footer
// transfer, then loaded into the result register, which raises out_valid.
// reset: hunting for the header, held values zero, registers at defaults,
// queue and result register empty.
// receiver stall: the result register holds; further frames fill the queue and
// in_stall rises only when the queue is full.
`default_nettype none

module uart_frame_deframer_with_timeout #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_opcode,
  input  wire logic        [ufd_pkg::ByteW-1:0]       in_rx_byte,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [ufd_pkg::ByteW-1:0]       out_frame_cmd,
  output logic signed      [ufd_pkg::WordW-1:0]       out_deviation,
  output logic             [ufd_pkg::ByteW-1:0]       out_digit,
  output logic             [ufd_pkg::ByteW-1:0]       out_link_status,
  output logic signed      [ufd_pkg::WordW-1:0]       out_track,
  output logic                                        out_digit_upd,
  output logic                                        out_track_upd,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic        [ufd_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic        [ufd_pkg::ByteW-1:0]       cfg_wdata
);

  ufd_pkg::cfg_t   cfg_r;
  ufd_pkg::frame_t push_frame, pop_frame;
  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= ufd_pkg::TIMEOUT_RST;
      cfg_r.header_value  <= ufd_pkg::HEADER_RST;
      cfg_r.footer_value  <= ufd_pkg::FOOTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ufd_pkg::REG_TIMEOUT) begin
        cfg_r.timeout_ticks <= cfg_wdata;
      end else if (cfg_index == ufd_pkg::REG_HEADER) begin
        cfg_r.header_value <= cfg_wdata;
      end else if (cfg_index == ufd_pkg::REG_FOOTER) begin
        cfg_r.footer_value <= cfg_wdata;
      end
    end
  end

  ufd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_rx_byte (in_rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame)
  );

  ufd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  ufd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_frame       (pop_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_cmd   (out_frame_cmd),
    .out_deviation   (out_deviation),
    .out_digit       (out_digit),
    .out_link_status (out_link_status),
    .out_track       (out_track),
    .out_digit_upd   (out_digit_upd),
    .out_track_upd   (out_track_upd)
  );

endmodule

`default_nettype wire

// File: rtl/core/ufd_checker.sv
// port-level checker for the uart frame deframer and its bind
`default_nettype none

module ufd_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [ufd_pkg::ByteW-1:0] out_frame_cmd,
  input wire logic                      out_digit_upd,
  input wire logic                      out_track_upd
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_digit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digit_upd |-> out_frame_cmd == ufd_pkg::CMD_DIGIT)
    else $error("digit update flag without digit command");

  a_track_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_track_upd |-> out_frame_cmd == ufd_pkg::CMD_TRACK && !out_digit_upd)
    else $error("track update flag without track command");

endmodule

bind uart_frame_deframer_with_timeout ufd_checker u_ufd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_frame_cmd (out_frame_cmd),
  .out_digit_upd (out_digit_upd),
  .out_track_upd (out_track_upd)
);

`default_nettype wire
